>>> rtl/psag_pkg.sv
package psag_pkg;

	// request codes
	localparam logic [1:0] REQ_NEXT    = 2'd0;
	localparam logic [1:0] REQ_RESTART = 2'd1;
	localparam logic [1:0] REQ_JUMP    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_IMG_W    = 2'd0;
	localparam logic [1:0] CFG_IMG_H    = 2'd1;
	localparam logic [1:0] CFG_FIRST_L2 = 2'd2;

	// configuration reset values
	localparam int          IMG_W_RST    = 640;
	localparam int          IMG_H_RST    = 480;
	localparam logic [3:0]  FIRST_L2_RST = 4'd4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic commit;
	} psag_cmd_t;

	typedef struct packed {
		logic res_ready;
		logic slot_free;
	} psag_stat_t;

endpackage

>>> rtl/psag_req_if.sv
interface psag_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [3:0] start_stride_log2;

	modport source (output valid, output req_type, output start_stride_log2, input ready);
	modport sink (input valid, input req_type, input start_stride_log2, output ready);
endinterface

>>> rtl/psag_cfg_if.sv
interface psag_cfg_if #(parameter int COORD_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [1:0]            index;
	logic [COORD_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/psag_pt_if.sv
interface psag_pt_if #(parameter int COORD_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic                  point_valid;
	logic [COORD_BITS-1:0] x_coord;
	logic [COORD_BITS-1:0] y_coord;
	logic [15:0]           point_stride;
	logic                  layer_cross;

	modport source (output valid, output point_valid, output x_coord, output y_coord,
		output point_stride, output layer_cross, input ready);
	modport sink (input valid, input point_valid, input x_coord, input y_coord,
		input point_stride, input layer_cross, output ready);
endinterface

>>> rtl/psag_ctrl.sv
module psag_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  psag_pkg::psag_stat_t   stat,
	output psag_pkg::psag_cmd_t    cmd
);
	import psag_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!stat.res_ready) begin
					// skipped point (also a skipped layer origin), walk one more lattice step
					cmd.step = 1'b1;
				end else if (stat.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

>>> rtl/psag_dp.sv
module psag_dp #(
	parameter int COORD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psag_pkg::psag_cmd_t    cmd,
	output psag_pkg::psag_stat_t   stat,
	input  logic [1:0]             req_type,
	input  logic [3:0]             start_stride_log2,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [COORD_BITS-1:0]  cfg_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   point_valid,
	output logic [COORD_BITS-1:0]  x_coord,
	output logic [COORD_BITS-1:0]  y_coord,
	output logic [15:0]            point_stride,
	output logic                   layer_cross
);
	import psag_pkg::*;

	localparam int PB = COORD_BITS + 1;

	logic [COORD_BITS-1:0] img_w_q;
	logic [COORD_BITS-1:0] img_h_q;
	logic [3:0]            first_l2_q;

	logic [PB-1:0] cur_x_q;
	logic [PB-1:0] cur_y_q;
	logic [3:0]    cur_l2_q;
	phase_t        phase_q;

	logic [1:0] req_q;
	logic [3:0] start_q;
	logic       crossed_q;

	logic                  out_valid_q;
	logic                  pv_q;
	logic [COORD_BITS-1:0] ox_q;
	logic [COORD_BITS-1:0] oy_q;
	logic [15:0]           ostride_q;
	logic                  ochg_q;

	// one lattice step
	logic [PB-1:0] step_sz;
	logic [PB-1:0] x_sum;
	logic [PB-1:0] y_sum;
	logic [PB-1:0] nx;
	logic [PB-1:0] ny;
	logic [3:0]    nl;
	logic          scan_end;
	logic          lvl_down;
	logic [PB-1:0] low_mask;
	logic          seen;
	logic          run_case;

	logic                  res_pv;
	logic [COORD_BITS-1:0] res_x;
	logic [COORD_BITS-1:0] res_y;
	logic [15:0]           res_stride;
	logic                  res_chg;

	assign step_sz = PB'(1) << cur_l2_q;
	assign x_sum   = cur_x_q + step_sz;
	assign y_sum   = cur_y_q + step_sz;

	always_comb begin
		nx       = x_sum;
		ny       = cur_y_q;
		nl       = cur_l2_q;
		scan_end = 1'b0;
		lvl_down = 1'b0;
		if (x_sum >= {1'b0, img_w_q}) begin
			nx = '0;
			ny = y_sum;
			if (y_sum >= {1'b0, img_h_q}) begin
				if (cur_l2_q == 4'd0) begin
					scan_end = 1'b1;
				end else begin
					lvl_down = 1'b1;
					nl       = cur_l2_q - 4'd1;
					ny       = '0;
				end
			end
		end
	end

	// points on the grid of twice the stride were given by a coarser layer
	always_comb begin
		for (int i = 0; i < PB; i++) begin
			low_mask[i] = (i <= int'(nl));
		end
	end

	assign seen     = (nl != first_l2_q) && (((nx | ny) & low_mask) == '0);
	assign run_case = (req_q == REQ_NEXT) && (phase_q == PH_RUN);

	assign stat.res_ready = run_case ? (scan_end || !seen) : 1'b1;
	assign stat.slot_free = !out_valid_q || out_ready;

	always_comb begin
		res_pv     = 1'b0;
		res_x      = '0;
		res_y      = '0;
		res_stride = '0;
		res_chg    = 1'b0;
		if (req_q == REQ_NEXT) begin
			case (phase_q)
				PH_IDLE: begin
					res_pv     = 1'b1;
					res_stride = 16'(1) << first_l2_q;
				end
				PH_RUN: begin
					res_chg = crossed_q || lvl_down;
					if (!scan_end) begin
						res_pv     = 1'b1;
						res_x      = nx[COORD_BITS-1:0];
						res_y      = ny[COORD_BITS-1:0];
						res_stride = 16'(1) << nl;
					end
				end
				default: res_pv = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q    <= COORD_BITS'(IMG_W_RST);
			img_h_q    <= COORD_BITS'(IMG_H_RST);
			first_l2_q <= FIRST_L2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMG_W:    img_w_q    <= cfg_data;
				CFG_IMG_H:    img_h_q    <= cfg_data;
				CFG_FIRST_L2: first_l2_q <= cfg_data[3:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			cur_l2_q  <= '0;
			phase_q   <= PH_IDLE;
			crossed_q <= 1'b0;
		end else if (cmd.accept) begin
			crossed_q <= 1'b0;
		end else if (cmd.step) begin
			cur_x_q   <= nx;
			cur_y_q   <= ny;
			cur_l2_q  <= nl;
			crossed_q <= crossed_q || lvl_down;
		end else if (cmd.commit) begin
			case (req_q)
				REQ_RESTART: begin
					cur_x_q  <= '0;
					cur_y_q  <= '0;
					cur_l2_q <= '0;
					phase_q  <= PH_IDLE;
				end
				REQ_JUMP: begin
					cur_x_q  <= '0;
					cur_y_q  <= '0;
					cur_l2_q <= start_q;
					phase_q  <= PH_RUN;
				end
				REQ_NEXT: begin
					case (phase_q)
						PH_IDLE: begin
							cur_x_q  <= '0;
							cur_y_q  <= '0;
							cur_l2_q <= first_l2_q;
							phase_q  <= PH_RUN;
						end
						PH_RUN: begin
							cur_x_q  <= nx;
							cur_y_q  <= ny;
							cur_l2_q <= nl;
							phase_q  <= scan_end ? PH_DONE : PH_RUN;
						end
						default: phase_q <= phase_q;
					endcase
				end
				default: phase_q <= phase_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q   <= req_type;
			start_q <= start_stride_log2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.commit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pv_q      <= res_pv;
			ox_q      <= res_x;
			oy_q      <= res_y;
			ostride_q <= res_stride;
			ochg_q    <= res_chg;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_valid  = pv_q;
	assign x_coord      = ox_q;
	assign y_coord      = oy_q;
	assign point_stride = ostride_q;
	assign layer_cross  = ochg_q;

endmodule

>>> rtl/progressive_scan_address_generator_core.sv
// Coarse-to-fine raster scan address generator. Each request is one item and
// gives exactly one result item. A next-point item is accepted and then,
// when the next lattice point is new, committed from the step unit. Every
// point skipped because a coarser layer already gave it is walked over by
// the step unit, which moves the position registers by one stride per
// cycle; a layer change lands on the origin of the finer layer, which is
// such a skipped point unless that layer is the first one. Restart,
// start-at-stride and a next request outside a running scan are committed
// without a step. The result sits in an output register, so a new request
// is accepted while the previous result waits to be taken; a finished item
// then holds in the step unit until that register frees.
// Configuration writes are taken every cycle and do not restart the scan.
module progressive_scan_address_generator_core #(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	psag_req_if.sink    req,
	psag_cfg_if.sink    cfg,
	psag_pt_if.source   pt
);
	import psag_pkg::*;

	psag_cmd_t  cmd;
	psag_stat_t stat;

	assign cfg.ready = 1'b1;

	psag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	psag_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.req_type          (req.req_type),
		.start_stride_log2 (req.start_stride_log2),
		.cfg_we            (cfg.valid && cfg.ready),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.out_ready         (pt.ready),
		.out_valid         (pt.valid),
		.point_valid       (pt.point_valid),
		.x_coord           (pt.x_coord),
		.y_coord           (pt.y_coord),
		.point_stride      (pt.point_stride),
		.layer_cross       (pt.layer_cross)
	);

`ifndef SYNTHESIS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> pt.valid)
		else $error("committed result not presented");

	a_stride_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && pt.point_valid) |-> $onehot(pt.point_stride))
		else $error("point stride not a power of two");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && !pt.point_valid) |->
		(pt.x_coord == '0 && pt.y_coord == '0 && pt.point_stride == '0))
		else $error("result without point carries nonzero fields");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.commit) |-> !req.ready)
		else $error("request taken while an item is in work");
`endif

endmodule
